FILE: rtl/jmss_pkg.sv
package jmss_pkg;

  typedef enum logic [3:0] {
    PH_PREFIX  = 4'd0,
    PH_ZEROS   = 4'd1,
    PH_MARKER  = 4'd2,
    PH_ENT     = 4'd3,
    PH_ENT_FF  = 4'd4,
    PH_FILL    = 4'd5,
    PH_LEN_HI  = 4'd6,
    PH_LEN_LO  = 4'd7,
    PH_APPTAG  = 4'd8,
    PH_BODY    = 4'd9,
    PH_DONE    = 4'd10
  } phase_t;

  localparam logic [2:0] V_RUN        = 3'd0;
  localparam logic [2:0] V_OK         = 3'd1;
  localparam logic [2:0] V_SHORT      = 3'd2;
  localparam logic [2:0] V_MISSING_FF = 3'd3;
  localparam logic [2:0] V_STRAY_0    = 3'd4;

  localparam int HoldDepth = 9;

  localparam logic [7:0] M_FF  = 8'hff;
  localparam logic [7:0] M_SOI = 8'hd8;
  localparam logic [7:0] M_EOI = 8'hd9;
  localparam logic [7:0] M_SOS = 8'hda;
  localparam logic [7:0] M_RST0 = 8'hd0;
  localparam logic [7:0] M_RST7 = 8'hd7;
  localparam logic [7:0] M_TEM = 8'h01;
  localparam logic [7:0] M_APP2 = 8'he2;

  localparam logic [0:0] REG_SPLIT = 1'd0;

  // One decoded item: up to nine bytes plus an optional verdict
  typedef struct packed {
    logic [3:0]             n_bytes;
    logic [HoldDepth*8-1:0] bytes;
    logic                   end_last;
    logic [2:0]             verdict;
    logic [7:0]             image_number;
  } cmd_t;

endpackage

FILE: rtl/jpeg_marker_stream_splitter_unit.sv
// A byte result passes through the front output register and the back queue.
// Throughput: one input beat per cycle while res_ready stays high and each
//   beat yields at most one result; a beat with more holds the output side.
// The two-entry command queue between decoder and emitter absorbs bursts.
// Reset (rst, synchronous, active high) clears parser state, counters and
//   split_enable; the header holding buffer needs no reset.
module jpeg_marker_stream_splitter_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_data,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [7:0]  out_byte,
  output logic        out_valid,
  output logic [7:0]  image_number,
  output logic        image_end,
  output logic [2:0]  verdict,
  output logic        last_of_run
);
  import jmss_pkg::*;

  logic split_enable;
  logic cv, cr;
  cmd_t cmd;

  assign pready = 1'b1;
  assign prdata = (paddr[1:0] == {REG_SPLIT, 1'b0}) ? {31'd0, split_enable} : 32'd0;

  // config register
  always_ff @(posedge clk) begin
    if (rst) split_enable <= 1'b0;
    else if (psel && penable && pwrite && paddr == {REG_SPLIT, 1'b0})
      split_enable <= pwdata[0];
  end

  jmss_front u_front (
    .clk, .rst, .split_enable, .in_valid, .in_ready, .data_byte, .end_of_data,
    .cmd_valid(cv), .cmd_ready(cr), .cmd
  );

  jmss_back u_back (
    .clk, .rst, .cmd_valid(cv), .cmd_ready(cr), .cmd,
    .out_valid_beat(res_valid), .out_ready(res_ready), .out_byte, .out_valid,
    .image_number, .image_end, .verdict, .last_of_run
  );

endmodule

FILE: rtl/jmss_front.sv
module jmss_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              split_enable,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        data_byte,
  input  logic              end_of_data,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output jmss_pkg::cmd_t    cmd
);
  import jmss_pkg::*;

  phase_t      phase, phase_next;
  logic        seen_eoi, seen_eoi_next;
  logic        image_open, image_open_next;
  logic        skip_segment, skip_segment_next;
  logic [15:0] segment_remaining, segment_remaining_next;
  logic [7:0]  current_marker, current_marker_next;
  logic [7:0]  header_hold [HoldDepth];
  logic [7:0]  hold_next [HoldDepth];
  logic [3:0]  hold_count, hold_count_next;
  logic [7:0]  image_count, image_count_next;
  logic        done, done_next;

  logic [7:0]  eb [HoldDepth];
  logic [3:0]  en;
  logic        eend;
  logic [2:0]  v;
  logic [15:0] len;
  logic        tag_hit;
  cmd_t        c;

  // output register, one command
  logic        oval;
  cmd_t        ocmd;

  logic        acc;
  assign in_ready  = !oval || cmd_ready;
  assign acc       = in_valid && in_ready;
  assign cmd_valid = oval;
  assign cmd       = ocmd;

  // decode one byte
  always_comb begin
    logic       io;
    logic [3:0] hc;
    phase_next = phase;
    seen_eoi_next = seen_eoi;
    image_open_next = image_open;
    skip_segment_next = skip_segment;
    segment_remaining_next = segment_remaining;
    current_marker_next = current_marker;
    hold_count_next = hold_count;
    image_count_next = image_count;
    done_next = done;
    hold_next = header_hold;
    for (int i = 0; i < HoldDepth; i++) eb[i] = 8'h00;
    en = 4'd0;
    eend = 1'b0;
    v = V_RUN;
    len = 16'd0;
    tag_hit = 1'b0;
    io = image_open;
    hc = hold_count;

    case (phase)
      PH_PREFIX: begin
        if (end_of_data) v = seen_eoi ? V_OK : V_SHORT;
        else if (seen_eoi && data_byte == 8'h00) phase_next = PH_ZEROS;
        else if (data_byte != M_FF) v = V_MISSING_FF;
        else phase_next = PH_MARKER;
      end
      PH_ZEROS: begin
        if (end_of_data) v = V_SHORT;
        else if (data_byte == M_FF) phase_next = PH_MARKER;
        else if (data_byte != 8'h00) v = V_MISSING_FF;
      end
      PH_ENT: begin
        if (end_of_data) v = seen_eoi ? V_OK : V_SHORT;
        else if (data_byte == M_FF) phase_next = PH_ENT_FF;
        else if (io) begin
          eb[0] = data_byte;
          en = 4'd1;
        end
      end
      PH_LEN_HI: begin
        if (end_of_data) v = V_SHORT;
        else begin
          segment_remaining_next = {data_byte, 8'h00};
          if (current_marker == M_APP2) begin
            if (hc < 4'(HoldDepth)) begin
              hold_next[hc] = data_byte;
              hold_count_next = hc + 4'd1;
            end
          end else if (io) begin
            eb[0] = data_byte;
            en = 4'd1;
          end
          phase_next = PH_LEN_LO;
        end
      end
      PH_LEN_LO: begin
        if (end_of_data) v = V_SHORT;
        else begin
          len = segment_remaining | {8'h00, data_byte};
          segment_remaining_next = (len >= 16'd2) ? len - 16'd2 : 16'd0;
          if (current_marker == M_APP2) begin
            if (hc < 4'(HoldDepth)) begin
              hold_next[hc] = data_byte;
              hc = hc + 4'd1;
            end
            hold_count_next = hc;
            if (len >= 16'd7) phase_next = PH_APPTAG;
            else begin
              if (io) begin
                for (int i = 0; i < HoldDepth; i++) eb[i] = hold_next[i];
                en = hc;
              end
              hold_count_next = 4'd0;
              phase_next = (segment_remaining_next != 16'd0) ? PH_BODY : PH_PREFIX;
            end
          end else begin
            if (io) begin
              eb[0] = data_byte;
              en = 4'd1;
            end
            phase_next = (segment_remaining_next != 16'd0) ? PH_BODY : PH_PREFIX;
          end
        end
      end
      PH_APPTAG: begin
        if (end_of_data) v = V_SHORT;
        else begin
          if (hc < 4'(HoldDepth)) begin
            hold_next[hc] = data_byte;
            hc = hc + 4'd1;
          end
          hold_count_next = hc;
          if (segment_remaining != 16'd0)
            segment_remaining_next = segment_remaining - 16'd1;
          if (hc >= 4'(HoldDepth)) begin
            tag_hit = hold_next[4] == 8'h4d && hold_next[5] == 8'h50 &&
                      hold_next[6] == 8'h46 && hold_next[7] == 8'h00;
            if (tag_hit) skip_segment_next = 1'b1;
            else if (io) begin
              for (int i = 0; i < HoldDepth; i++) eb[i] = hold_next[i];
              en = hc;
            end
            hold_count_next = 4'd0;
            phase_next = (segment_remaining_next != 16'd0) ? PH_BODY : PH_PREFIX;
          end
        end
      end
      PH_BODY: begin
        if (end_of_data) v = V_SHORT;
        else begin
          if (!skip_segment && io) begin
            eb[0] = data_byte;
            en = 4'd1;
          end
          segment_remaining_next = (segment_remaining != 16'd0) ?
                                   segment_remaining - 16'd1 : 16'd0;
          if (segment_remaining_next == 16'd0) phase_next = PH_PREFIX;
        end
      end
      PH_MARKER, PH_ENT_FF, PH_FILL: begin
        if (end_of_data) v = V_SHORT;
        else if (phase == PH_ENT_FF &&
                 (data_byte == 8'h00 || (data_byte >= M_RST0 && data_byte <= M_RST7))) begin
          if (io) begin
            eb[0] = M_FF;
            eb[1] = data_byte;
            en = 4'd2;
          end
          phase_next = PH_ENT;
        end else if (phase == PH_ENT_FF && data_byte == M_FF) begin
          phase_next = PH_FILL;
        end else if (phase == PH_FILL && data_byte == M_FF) begin
          phase_next = PH_FILL;
        end else begin
          // marker code
          if (data_byte == 8'h00) v = V_STRAY_0;
          else if (data_byte == M_SOI) begin
            seen_eoi_next = 1'b0;
            if (split_enable) begin
              if (image_count != 8'hff) image_count_next = image_count + 8'd1;
              io = 1'b1;
              image_open_next = 1'b1;
            end
            if (io) begin
              eb[0] = M_FF;
              eb[1] = M_SOI;
              en = 4'd2;
            end
            phase_next = PH_PREFIX;
          end else if (data_byte == M_EOI) begin
            seen_eoi_next = 1'b1;
            if (io) begin
              eb[0] = M_FF;
              eb[1] = M_EOI;
              en = 4'd2;
              eend = 1'b1;
            end
            image_open_next = 1'b0;
            phase_next = PH_PREFIX;
          end else if (data_byte >= M_RST0 && data_byte <= M_RST7) begin
            phase_next = PH_PREFIX;
          end else if (data_byte == M_TEM || data_byte == M_SOS) begin
            if (io) begin
              eb[0] = M_FF;
              eb[1] = data_byte;
              en = 4'd2;
            end
            phase_next = (data_byte == M_SOS) ? PH_ENT : PH_PREFIX;
          end else begin
            current_marker_next = data_byte;
            skip_segment_next = 1'b0;
            if (data_byte == M_APP2) begin
              hold_next[0] = M_FF;
              hold_next[1] = data_byte;
              hold_count_next = 4'd2;
            end else begin
              hold_count_next = 4'd0;
              if (io) begin
                eb[0] = M_FF;
                eb[1] = data_byte;
                en = 4'd2;
              end
            end
            phase_next = PH_LEN_HI;
          end
        end
      end
      default: phase_next = phase;
    endcase

    if (v != V_RUN) begin
      done_next = 1'b1;
      phase_next = PH_DONE;
    end
  end

  always_comb begin
    c.n_bytes = en;
    for (int i = 0; i < HoldDepth; i++) c.bytes[i*8 +: 8] = eb[i];
    c.end_last = eend;
    c.verdict = v;
    c.image_number = image_count_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_PREFIX;
      seen_eoi <= 1'b0;
      image_open <= 1'b0;
      skip_segment <= 1'b0;
      segment_remaining <= 16'd0;
      current_marker <= 8'h00;
      hold_count <= 4'd0;
      image_count <= 8'd0;
      done <= 1'b0;
      oval <= 1'b0;
    end else begin
      if (acc && !done) begin
        phase <= phase_next;
        seen_eoi <= seen_eoi_next;
        image_open <= image_open_next;
        skip_segment <= skip_segment_next;
        segment_remaining <= segment_remaining_next;
        current_marker <= current_marker_next;
        hold_count <= hold_count_next;
        image_count <= image_count_next;
        done <= done_next;
      end
      if (acc && !done && (en != 4'd0 || v != V_RUN)) oval <= 1'b1;
      else if (cmd_ready) oval <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !done) begin
      header_hold <= hold_next;
      ocmd <= c;
    end
  end

endmodule

FILE: rtl/jmss_back.sv
module jmss_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  jmss_pkg::cmd_t cmd,
  output logic           out_valid_beat,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           out_valid,
  output logic [7:0]     image_number,
  output logic           image_end,
  output logic [2:0]     verdict,
  output logic           last_of_run
);
  import jmss_pkg::*;

  // small queue of two commands
  cmd_t       q [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic [3:0] idx;
  logic [3:0] total;
  logic       fire, pop, push;
  cmd_t       h;

  assign h = q[rp];
  assign cmd_ready = cnt != 2'd2;
  assign push = cmd_valid && cmd_ready;
  assign out_valid_beat = cnt != 2'd0;
  assign fire = out_valid_beat && out_ready;
  assign total = h.n_bytes + ((h.verdict != V_RUN) ? 4'd1 : 4'd0);
  assign pop = fire && (idx + 4'd1 >= total);

  always_comb begin
    out_byte = 8'h00;
    for (int i = 0; i < HoldDepth; i++)
      if (idx == 4'(i)) out_byte = h.bytes[i*8 +: 8];
    out_valid = idx < h.n_bytes;
    if (!out_valid) out_byte = 8'h00;
    image_number = h.image_number;
    image_end = out_valid && h.end_last && (idx + 4'd1 == h.n_bytes);
    verdict = out_valid ? V_RUN : h.verdict;
    last_of_run = idx + 4'd1 >= total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
      idx <= 4'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) begin
        rp <= ~rp;
        idx <= 4'd0;
      end else if (fire) idx <= idx + 4'd1;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wp] <= cmd;
  end

endmodule

FILE: rtl/jmss_checker.sv
module jmss_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic       out_valid,
  input logic       image_end,
  input logic [2:0] verdict,
  input logic       last_of_run,
  input logic [7:0] image_number
);
  import jmss_pkg::*;

  a_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(image_number))
    else $error("result changed while stalled");
  a_vbyte: assert property (@(posedge clk) disable iff (rst)
    res_valid && out_valid |-> verdict == V_RUN)
    else $error("verdict on byte beat");
  a_vlast: assert property (@(posedge clk) disable iff (rst)
    res_valid && !out_valid |-> last_of_run && verdict != V_RUN)
    else $error("verdict beat malformed");
  a_end: assert property (@(posedge clk) disable iff (rst)
    res_valid && image_end |-> out_valid && last_of_run)
    else $error("image end not on last byte");
endmodule

bind jpeg_marker_stream_splitter_unit jmss_checker u_chk (
  .clk, .rst, .res_valid, .res_ready, .out_valid, .image_end, .verdict,
  .last_of_run, .image_number
);
